>>> hw/rtl/rlfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and colour helper functions for the LED frame renderer.
// Depends on nothing; rlfr_front, rlfr_back, the top level and the testbench import it.
package rlfr_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_ENABLE   = 3'd0;
	localparam logic [2:0] REG_MODE     = 3'd1;
	localparam logic [2:0] REG_HUE_STEP = 3'd2;
	localparam logic [2:0] REG_SAT      = 3'd3;
	localparam logic [2:0] REG_LED0_RGB = 3'd4;
	localparam logic [2:0] REG_LED1_RGB = 3'd5;
	localparam logic [2:0] REG_LED2_RGB = 3'd6;

	// Animation modes; the unused fourth code falls back to static colours.
	localparam logic [1:0] MODE_STATIC  = 2'd0;
	localparam logic [1:0] MODE_RAINBOW = 2'd1;
	localparam logic [1:0] MODE_WAVE    = 2'd2;

	// Input item kinds.
	localparam logic FUNC_LEVEL = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Colour arithmetic constants.
	localparam logic [7:0] REGION_STEPS = 8'd43;
	localparam logic [7:0] WAVE_OFFSET  = 8'd50;
	localparam logic [7:0] FULL_SCALE   = 8'd255;
	localparam logic [7:0] REM_SCALE    = 8'd6;
	localparam logic [4:0] MAX_STEP     = 5'd25;

	// Reset values of the configuration registers.
	localparam logic [4:0]  HUE_STEP_RESET = 5'd5;
	localparam logic [7:0]  SAT_RESET      = 8'd255;
	localparam logic [23:0] LED_RGB_RESET  = 24'hFF4500;

	// Render command passed from the front end to the colour back end.
	typedef struct packed {
		logic [7:0] bright;
		logic [7:0] hue;
	} cmd_t;

	// One LED colour word.
	typedef struct packed {
		logic [1:0] led_index;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] blue;
		logic       frame_end;
	} res_t;

	// Configuration seen by the colour back end.
	typedef struct packed {
		logic [1:0]       anim_mode;
		logic [7:0]       sat_level;
		logic [2:0][23:0] led_rgb;
	} draw_cfg_t;

	// Hue region in steps of 43.
	function automatic logic [2:0] region_of(input logic [7:0] hue);
		logic [2:0] r;
		if (hue < 8'd43) r = 3'd0;
		else if (hue < 8'd86) r = 3'd1;
		else if (hue < 8'd129) r = 3'd2;
		else if (hue < 8'd172) r = 3'd3;
		else if (hue < 8'd215) r = 3'd4;
		else r = 3'd5;
		return r;
	endfunction

	// First hue of a region.
	function automatic logic [7:0] region_base(input logic [2:0] region);
		logic [7:0] b;
		case (region)
			3'd0: b = 8'd0;
			3'd1: b = 8'd43;
			3'd2: b = 8'd86;
			3'd3: b = 8'd129;
			3'd4: b = 8'd172;
			default: b = 8'd215;
		endcase
		return b;
	endfunction

	// Exact quotient by 255 for a product of two bytes. With x = 256*hi + lo the
	// remainder estimate lo + hi stays below 510, so one correction step suffices.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [8:0] s;
		logic [7:0] q;
		s = {1'b0, x[7:0]} + {1'b0, x[15:8]};
		q = x[15:8] + ((s >= {1'b0, FULL_SCALE}) ? 8'd1 : 8'd0);
		return q;
	endfunction

endpackage

>>> hw/rtl/rlfr_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue used for the render command queue and the result queue.
// Depends on nothing beyond the widths given by its parameters.
module rlfr_fifo #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> hw/rtl/rlfr_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items, keeps brightness and hue phase, decides whether a frame
// is drawn and queues a render command. Depends on rlfr_pkg.
module rlfr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          func,
	input  logic [7:0]    level,
	input  logic          redraw,
	input  logic          enable,
	input  logic [1:0]    anim_mode,
	input  logic [4:0]    hue_step,
	output logic          cmd_push,
	output rlfr_pkg::cmd_t cmd,
	input  logic          cmd_full
);

	import rlfr_pkg::*;

	logic [7:0] bright_q;
	logic [7:0] hue_q;
	logic [7:0] bright_next;
	logic [7:0] hue_next;
	logic [4:0] step;
	logic       animating;
	logic       draw;
	logic       accept;

	assign full   = cmd_full;
	assign accept = push & ~cmd_full;

	// Clamp the hue step into its working range.
	always_comb begin
		if (hue_step == 5'd0) step = 5'd1;
		else if (hue_step > MAX_STEP) step = MAX_STEP;
		else step = hue_step;
	end

	assign animating = (anim_mode == MODE_RAINBOW) || (anim_mode == MODE_WAVE);

	// Classify the item and work out the state it leaves behind.
	always_comb begin
		if (func == FUNC_LEVEL) begin
			bright_next = level;
			hue_next    = hue_q;
			draw        = enable & (redraw | (level != bright_q));
		end else begin
			bright_next = bright_q;
			draw        = enable & (bright_q != 8'd0) & animating;
			hue_next    = draw ? hue_q + {3'd0, step} : hue_q;
		end
	end

	assign cmd_push    = accept & draw;
	assign cmd.bright  = bright_next;
	assign cmd.hue     = hue_next;

	// Brightness and hue phase update on every transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= '0;
			hue_q    <= '0;
		end else if (accept) begin
			bright_q <= bright_next;
			hue_q    <= hue_next;
		end
	end

endmodule

>>> hw/rtl/rlfr_back.sv
`timescale 1ns / 1ps
// Back end: walks the LEDs of each render command through a shared three-stage colour
// pipeline (hue decode, first products, final colour). Depends on rlfr_pkg.
module rlfr_back #(
	parameter int unsigned LED_COUNT = 3,
	parameter int unsigned OUT_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlfr_pkg::draw_cfg_t cfg,
	input  logic                cmd_empty,
	input  rlfr_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                res_push,
	output rlfr_pkg::res_t      res,
	input  logic                res_pop
);

	import rlfr_pkg::*;

	localparam int unsigned CNT_W = $clog2(OUT_DEPTH + 1);

	logic [1:0]       led_q;
	logic [CNT_W-1:0] cnt_q;
	logic             issue;
	logic             last;
	logic             hsv;
	logic             wave;
	logic [7:0]       hue_w;
	logic [2:0]       region_w;
	logic [7:0]       rem_w;
	logic [7:0]       sat_w;

	logic             v_s1;
	logic [1:0]       led_s1;
	logic             last_s1;
	logic             hsv_s1;
	logic [2:0]       region_s1;
	logic [7:0]       rem_s1;
	logic [7:0]       sat_s1;
	logic [7:0]       bright_s1;
	logic [23:0]      chan_s1;

	logic             v_s2;
	logic [1:0]       led_s2;
	logic             last_s2;
	logic             hsv_s2;
	logic [2:0]       region_s2;
	logic [7:0]       bright_s2;
	logic [7:0]       psub_s2;
	logic [15:0]      m0_s2;
	logic [15:0]      m1_s2;
	logic [15:0]      m2_s2;

	logic             v_s3;
	res_t             res_s3;

	logic [15:0]      pp;
	logic [15:0]      pq;
	logic [15:0]      pt;
	logic [7:0]       r_w;
	logic [7:0]       g_w;
	logic [7:0]       b_w;

	// Issue one LED a cycle while a command waits and results in flight plus queued stay below the queue depth.
	assign issue   = ~cmd_empty & (cnt_q < CNT_W'(OUT_DEPTH));
	assign last    = (led_q == 2'(LED_COUNT - 1));
	assign cmd_pop = issue & last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= '0;
			cnt_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			if (issue) begin
				led_q <= last ? 2'd0 : led_q + 2'd1;
			end
			cnt_q <= cnt_q + CNT_W'(issue) - CNT_W'(res_pop);
			v_s1  <= issue;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
		end
	end

	// Stage 1: hue of this LED, its region and the position inside the region.
	assign hsv      = (cfg.anim_mode == MODE_RAINBOW) || (cfg.anim_mode == MODE_WAVE);
	assign wave     = (cfg.anim_mode == MODE_WAVE);
	assign hue_w    = cmd.hue + (wave ? 8'({6'd0, led_q} * WAVE_OFFSET) : 8'd0);
	assign region_w = region_of(hue_w);
	assign rem_w    = (hue_w - region_base(region_w)) * REM_SCALE;
	assign sat_w    = (cfg.sat_level == 8'd0) ? 8'd1 : cfg.sat_level;

	always_ff @(posedge clk) begin
		led_s1    <= led_q;
		last_s1   <= last;
		hsv_s1    <= hsv;
		region_s1 <= region_w;
		rem_s1    <= rem_w;
		sat_s1    <= sat_w;
		bright_s1 <= cmd.bright;
		chan_s1   <= cfg.led_rgb[led_q];
	end

	// Stage 2: saturation products for HSV, or colour times brightness for static mode.
	always_ff @(posedge clk) begin
		led_s2    <= led_s1;
		last_s2   <= last_s1;
		hsv_s2    <= hsv_s1;
		region_s2 <= region_s1;
		bright_s2 <= bright_s1;
		psub_s2   <= FULL_SCALE - sat_s1;
		if (hsv_s1) begin
			m0_s2 <= sat_s1 * rem_s1;
			m1_s2 <= sat_s1 * (FULL_SCALE - rem_s1);
		end else begin
			m0_s2 <= chan_s1[23:16] * bright_s1;
			m1_s2 <= chan_s1[15:8] * bright_s1;
		end
		m2_s2 <= chan_s1[7:0] * bright_s1;
	end

	// Stage 3: brightness products and the region's channel order, or division by 255 for static colours.
	assign pp = bright_s2 * psub_s2;
	assign pq = bright_s2 * (FULL_SCALE - m0_s2[15:8]);
	assign pt = bright_s2 * (FULL_SCALE - m1_s2[15:8]);

	always_comb begin
		if (hsv_s2) begin
			case (region_s2)
				3'd0: begin r_w = bright_s2; g_w = pt[15:8]; b_w = pp[15:8]; end
				3'd1: begin r_w = pq[15:8]; g_w = bright_s2; b_w = pp[15:8]; end
				3'd2: begin r_w = pp[15:8]; g_w = bright_s2; b_w = pt[15:8]; end
				3'd3: begin r_w = pp[15:8]; g_w = pq[15:8]; b_w = bright_s2; end
				3'd4: begin r_w = pt[15:8]; g_w = pp[15:8]; b_w = bright_s2; end
				default: begin r_w = bright_s2; g_w = pp[15:8]; b_w = pq[15:8]; end
			endcase
		end else begin
			r_w = div255(m0_s2);
			g_w = div255(m1_s2);
			b_w = div255(m2_s2);
		end
	end

	always_ff @(posedge clk) begin
		res_s3.led_index <= led_s2;
		res_s3.green     <= g_w;
		res_s3.red       <= r_w;
		res_s3.blue      <= b_w;
		res_s3.frame_end <= last_s2;
	end

	assign res_push = v_s3;
	assign res      = res_s3;

endmodule

>>> hw/rtl/rgb_led_frame_renderer.sv
`timescale 1ns / 1ps
// Top level of the LED frame renderer: configuration registers, front end, command queue,
// colour back end and result queue. Depends on rlfr_pkg, rlfr_fifo, rlfr_front, rlfr_back.
//
//   Channel   Handshake            Payload
//   input     push / full          func, level, redraw
//   result    empty / pop          led_index, green_out, red_out, blue_out, frame_end
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An input item is taken whenever the two-entry command queue has room.
// A drawn frame goes through the shared colour pipeline one LED per cycle while slots remain;
// each LED word passes the pipeline's stage registers before it reaches the result queue.
// The back end stops issuing while four words are in flight or queued; pop frees a slot.
// Reset clears brightness, hue phase, queues and pipeline valids; config takes its defaults.
module rgb_led_frame_renderer #(
	parameter int unsigned LED_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        func,
	input  logic [7:0]  level,
	input  logic        redraw,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  led_index,
	output logic [7:0]  green_out,
	output logic [7:0]  red_out,
	output logic [7:0]  blue_out,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	import rlfr_pkg::*;

	localparam int unsigned CMD_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 4;

	logic             enable_q;
	logic [1:0]       mode_q;
	logic [4:0]       step_q;
	logic [7:0]       sat_q;
	logic [2:0][23:0] rgb_q;

	draw_cfg_t        draw_cfg;
	cmd_t             cmd_in;
	cmd_t             cmd_out;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_pop;
	logic             cmd_empty;
	res_t             res_in;
	res_t             res_out;
	logic             res_push;
	logic             res_full;

	// Configuration writes; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q   <= MODE_STATIC;
			step_q   <= HUE_STEP_RESET;
			sat_q    <= SAT_RESET;
			rgb_q    <= {3{LED_RGB_RESET}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q  <= cfg_data[0];
				REG_MODE:     mode_q    <= cfg_data[1:0];
				REG_HUE_STEP: step_q    <= cfg_data[4:0];
				REG_SAT:      sat_q     <= cfg_data[7:0];
				REG_LED0_RGB: rgb_q[0]  <= cfg_data;
				REG_LED1_RGB: rgb_q[1]  <= cfg_data;
				REG_LED2_RGB: rgb_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign draw_cfg.anim_mode = mode_q;
	assign draw_cfg.sat_level = sat_q;
	assign draw_cfg.led_rgb   = rgb_q;

	// Front end.
	rlfr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.level     (level),
		.redraw    (redraw),
		.enable    (enable_q),
		.anim_mode (mode_q),
		.hue_step  (step_q),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.cmd_full  (cmd_full)
	);

	// Render commands between front and back.
	rlfr_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_out),
		.empty  (cmd_empty)
	);

	// Colour back end.
	rlfr_back #(
		.LED_COUNT (LED_COUNT),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (draw_cfg),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_pop   (pop & ~empty)
	);

	// Result queue; room is reserved by the back end before each issue.
	rlfr_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign led_index = res_out.led_index;
	assign green_out = res_out.green;
	assign red_out   = res_out.red;
	assign blue_out  = res_out.blue;
	assign frame_end = res_out.frame_end & ~res_full | res_out.frame_end;

endmodule

>>> hw/rtl/rlfr_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the LED frame renderer, bound to the top level.
// Depends only on the top level's ports and its LED_COUNT parameter.
module rlfr_checker #(
	parameter int unsigned LED_COUNT = 3
) (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] led_index,
	input logic [7:0] green_out,
	input logic [7:0] red_out,
	input logic [7:0] blue_out,
	input logic       frame_end
);

	// Only the last LED of a frame carries the frame end mark.
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (frame_end == (led_index == 2'(LED_COUNT - 1))))
		else $error("frame_end does not match the last LED index");

	// Inside a frame the next word shown is for the next LED.
	a_next_led: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !frame_end) |=> (empty || led_index == $past(led_index) + 2'd1))
		else $error("LED words of a frame out of order");

	// After a frame end the next word shown starts a new frame.
	a_new_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && frame_end) |=> (empty || led_index == 2'd0))
		else $error("frame does not start at LED zero");

	// A word that is not taken stays on the ports unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(led_index) && $stable(green_out)
			&& $stable(red_out) && $stable(blue_out) && $stable(frame_end)))
		else $error("waiting result changed before its transfer");

endmodule

bind rgb_led_frame_renderer rlfr_checker #(.LED_COUNT(LED_COUNT)) u_rlfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.empty     (empty),
	.pop       (pop),
	.led_index (led_index),
	.green_out (green_out),
	.red_out   (red_out),
	.blue_out  (blue_out),
	.frame_end (frame_end)
);

>>> tb/rgb_led_frame_renderer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_frame_renderer: directed tests, then random traffic.
// Depends on rlfr_pkg and the renderer RTL; LED words are predicted here and checked in order.
module rgb_led_frame_renderer_tb;
	import rlfr_pkg::*;

	localparam int unsigned LEDS = 3;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 12;
	localparam int LIMIT_CYCLES = 300000;
	localparam int RANDOM_PER_PHASE = 27;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        func = 1'b0;
	logic [7:0]  level = 8'd0;
	logic        redraw = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  led_index;
	logic [7:0]  green_out;
	logic [7:0]  red_out;
	logic [7:0]  blue_out;
	logic        frame_end;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [23:0] cfg_data = 24'd0;

	// Shadow copy of the configuration and the renderer state.
	logic        m_enable;
	logic [1:0]  m_mode;
	logic [4:0]  m_step;
	logic [7:0]  m_sat;
	logic [23:0] m_rgb [LEDS];
	logic [7:0]  bright;
	logic [7:0]  hue;

	// LED words still owed by the renderer, oldest first.
	res_t words_due [$];

	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;

	rgb_led_frame_renderer #(.LED_COUNT(LEDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.level(level),
		.redraw(redraw),
		.empty(empty),
		.pop(pop),
		.led_index(led_index),
		.green_out(green_out),
		.red_out(red_out),
		.blue_out(blue_out),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t ns: timeout with %0d LED words outstanding", $time, words_due.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Brightness scaling of one color byte.
	function automatic logic [7:0] scale_channel(input int unsigned c, input int unsigned b);
		return 8'((c * b) / 255);
	endfunction

	// Integer HSV conversion with hue regions of 43 steps.
	task automatic hsv_to_rgb(input int unsigned h, input int unsigned s, input int unsigned v,
			output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
		int unsigned region;
		int unsigned rem;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
		region = h / REGION_STEPS;
		rem = ((h - region * REGION_STEPS) * REM_SCALE) & 255;
		p = 8'((v * (255 - s)) >> 8);
		q = 8'((v * (255 - ((s * rem) >> 8))) >> 8);
		t = 8'((v * (255 - ((s * (255 - rem)) >> 8))) >> 8);
		case (region)
			0: begin r = 8'(v); g = t; b = p; end
			1: begin r = q; g = 8'(v); b = p; end
			2: begin r = p; g = 8'(v); b = t; end
			3: begin r = p; g = q; b = 8'(v); end
			4: begin r = t; g = p; b = 8'(v); end
			default: begin r = 8'(v); g = p; b = q; end
		endcase
	endtask

	// Queue the words of one frame drawn from the current shadow state.
	task automatic queue_frame();
		res_t w;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] h;
		logic [7:0] s;
		int i;
		s = (m_sat == 8'd0) ? 8'd1 : m_sat;
		for (i = 0; i < LEDS; i++) begin
			r = 8'd0;
			g = 8'd0;
			b = 8'd0;
			if (bright != 8'd0) begin
				if (m_mode == MODE_RAINBOW || m_mode == MODE_WAVE) begin
					h = hue;
					if (m_mode == MODE_WAVE)
						h = 8'(hue + WAVE_OFFSET * i);
					hsv_to_rgb(h, s, bright, r, g, b);
				end else begin
					r = scale_channel(m_rgb[i][23:16], bright);
					g = scale_channel(m_rgb[i][15:8], bright);
					b = scale_channel(m_rgb[i][7:0], bright);
				end
			end
			w.led_index = 2'(i);
			w.green = g;
			w.red = r;
			w.blue = b;
			w.frame_end = (i == LEDS - 1);
			words_due.push_back(w);
		end
	endtask

	// Update the shadow state for one accepted item and queue any frame it draws.
	task automatic predict_item(input logic f, input logic [7:0] lv, input logic rd);
		logic [7:0] prev;
		logic [4:0] stp;
		if (f == FUNC_LEVEL) begin
			prev = bright;
			bright = lv;
			if (m_enable && (rd || prev != lv))
				queue_frame();
		end else if (m_enable && bright != 8'd0 &&
				(m_mode == MODE_RAINBOW || m_mode == MODE_WAVE)) begin
			stp = m_step;
			if (stp == 5'd0)
				stp = 5'd1;
			if (stp > MAX_STEP)
				stp = MAX_STEP;
			hue = hue + {3'b000, stp};
			queue_frame();
		end
	endtask

	// Send one item, with random idle cycles ahead of it; push stays high after the transfer.
	task automatic send_cmd(input logic f, input logic [7:0] lv, input logic rd);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		level <= lv;
		redraw <= rd;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_item(f, lv, rd);
	endtask

	// Stop sending and wait until every owed word has arrived and the pipeline is quiet.
	task automatic wait_idle();
		push <= 1'b0;
		while (words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write transfer; the shadow copy follows at the same edge.
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ENABLE:   m_enable = data[0];
			REG_MODE:     m_mode = data[1:0];
			REG_HUE_STEP: m_step = data[4:0];
			REG_SAT:      m_sat = data[7:0];
			REG_LED0_RGB: m_rgb[0] = data;
			REG_LED1_RGB: m_rgb[1] = data;
			REG_LED2_RGB: m_rgb[2] = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	// Result side: check each transfer against the oldest owed word, then pick the next pop.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (words_due.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected LED word, expected none, actual led %0d G %0d R %0d B %0d",
					$time, led_index, green_out, red_out, blue_out);
			end else begin
				want = words_due.pop_front();
				check_field("led_index", want.led_index, led_index);
				check_field("green_out", want.green, green_out);
				check_field("red_out", want.red, red_out);
				check_field("blue_out", want.blue, blue_out);
				check_field("frame_end", want.frame_end, frame_end);
			end
		end
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// After reset the backlight is off: nothing is drawn, but brightness is kept.
	task automatic test_disabled_at_reset();
		send_cmd(FUNC_LEVEL, 8'd200, 1'b0);
		send_cmd(FUNC_TICK, 8'd0, 1'b0);
		wait_idle();
		write_reg(REG_ENABLE, 24'd1);
		// Unchanged brightness draws nothing unless a redraw is forced.
		send_cmd(FUNC_LEVEL, 8'd200, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd200, 1'b1);
	endtask

	// Static colors at full, minimal and zero brightness; ticks do nothing here.
	task automatic test_static_colors();
		wait_idle();
		write_reg(REG_LED0_RGB, 24'hFFFFFF);
		write_reg(REG_LED1_RGB, 24'h000000);
		write_reg(REG_LED2_RGB, 24'($urandom));
		send_cmd(FUNC_LEVEL, 8'd255, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd1, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd0, 1'b0);
		send_cmd(FUNC_TICK, 8'd255, 1'b1);
	endtask

	// Same hue on every LED; a tick while dark is ignored; zero saturation and zero step.
	task automatic test_rainbow_hue();
		wait_idle();
		write_reg(REG_MODE, {22'd0, MODE_RAINBOW});
		write_reg(REG_SAT, 24'd255);
		write_reg(REG_HUE_STEP, 24'd25);
		send_cmd(FUNC_TICK, 8'd0, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd255, 1'b0);
		repeat (3) send_cmd(FUNC_TICK, 8'd0, 1'b0);
		wait_idle();
		write_reg(REG_SAT, 24'd0);
		write_reg(REG_HUE_STEP, 24'd0);
		send_cmd(FUNC_TICK, 8'd0, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd1, 1'b1);
	endtask

	// Hue offset per LED, with a step above the allowed range.
	task automatic test_wave_offsets();
		wait_idle();
		write_reg(REG_MODE, {22'd0, MODE_WAVE});
		write_reg(REG_HUE_STEP, 24'd31);
		repeat (4) send_cmd(FUNC_TICK, 8'd0, 1'b0);
		wait_idle();
		write_reg(REG_SAT, 24'd128);
		send_cmd(FUNC_LEVEL, 8'd77, 1'b0);
	endtask

	// The spare mode code draws static colors and does not animate.
	task automatic test_fallback_mode();
		wait_idle();
		write_reg(REG_MODE, {22'd0, MODE_SPARE});
		send_cmd(FUNC_TICK, 8'd0, 1'b0);
		send_cmd(FUNC_LEVEL, 8'd90, 1'b0);
	endtask

	// A write to an unknown index is dropped; brightness set while off is used later.
	task automatic test_disabled_store();
		wait_idle();
		write_reg(REG_UNUSED, 24'($urandom));
		write_reg(REG_ENABLE, 24'd0);
		send_cmd(FUNC_LEVEL, 8'd10, 1'b0);
		wait_idle();
		write_reg(REG_ENABLE, 24'd1);
		write_reg(REG_MODE, {22'd0, MODE_RAINBOW});
		send_cmd(FUNC_TICK, 8'd0, 1'b0);
	endtask

	// New random settings, edge values included; junk in unused data bits.
	task automatic shuffle_config();
		int k;
		int i;
		logic [1:0] mode;
		logic [23:0] rgb;
		wait_idle();
		write_reg(REG_ENABLE, {23'($urandom), 1'($urandom_range(9) != 0)});
		k = $urandom_range(5);
		mode = (k < 2) ? MODE_RAINBOW : (k < 4) ? MODE_WAVE : (k == 4) ? MODE_STATIC : MODE_SPARE;
		write_reg(REG_MODE, {22'($urandom), mode});
		case ($urandom_range(4))
			0: write_reg(REG_HUE_STEP, {19'($urandom), 5'd0});
			1: write_reg(REG_HUE_STEP, {19'($urandom), 5'd1});
			2: write_reg(REG_HUE_STEP, {19'($urandom), 5'd25});
			3: write_reg(REG_HUE_STEP, {19'($urandom), 5'd31});
			default: write_reg(REG_HUE_STEP, 24'($urandom));
		endcase
		case ($urandom_range(4))
			0: write_reg(REG_SAT, {16'($urandom), 8'd0});
			1: write_reg(REG_SAT, {16'($urandom), 8'd1});
			2: write_reg(REG_SAT, {16'($urandom), 8'd255});
			default: write_reg(REG_SAT, 24'($urandom));
		endcase
		for (i = 0; i < LEDS; i++) begin
			k = $urandom_range(3);
			rgb = (k == 0) ? 24'h000000 : (k == 1) ? 24'hFFFFFF : 24'($urandom);
			write_reg(REG_LED0_RGB + 3'(i), rgb);
		end
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, 24'($urandom));
	endtask

	// Random items under one idling pattern; halfway through the sender waits for the frames.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int n;
		int k;
		shuffle_config();
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		for (n = 0; n < RANDOM_PER_PHASE; n++) begin
			if (n == RANDOM_PER_PHASE / 2)
				wait_idle();
			k = $urandom_range(99);
			if (k < 45)
				send_cmd(FUNC_TICK, 8'($urandom), 1'($urandom));
			else if (k < 55)
				send_cmd(FUNC_LEVEL, bright, 1'($urandom));
			else if (k < 62)
				send_cmd(FUNC_LEVEL, $urandom_range(1) ? 8'd255 : 8'd0, 1'($urandom));
			else
				send_cmd(FUNC_LEVEL, 8'($urandom), 1'($urandom));
		end
		wait_idle();
	endtask

	initial begin
		m_enable = 1'b0;
		m_mode = MODE_STATIC;
		m_step = HUE_STEP_RESET;
		m_sat = SAT_RESET;
		m_rgb[0] = LED_RGB_RESET;
		m_rgb[1] = LED_RGB_RESET;
		m_rgb[2] = LED_RGB_RESET;
		bright = 8'd0;
		hue = 8'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_at_reset();
		test_static_colors();
		test_rainbow_hue();
		test_wave_offsets();
		test_fallback_mode();
		test_disabled_store();
		test_random_traffic(0, 0);
		test_random_traffic(77, 0);
		test_random_traffic(0, 77);
		test_random_traffic(31, 31);

		wait_idle();
		repeat (20) @(posedge clk);
		if (words_due.size() != 0) begin
			errors++;
			$display("%0t ns: %0d LED words expected but never delivered", $time, words_due.size());
		end
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
